[design/qra_pkg.sv]
// shared types, constants and ordering table for the quadratic roots block
package qra_pkg;

    localparam int COEF_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int TOL_W      = 31;
    localparam int NUM_ORDERS = 6;
    localparam int ORD_W      = 3;

    localparam logic [1:0] OUT_INVALID = 2'd0;
    localparam logic [1:0] OUT_TWO     = 2'd1;
    localparam logic [1:0] OUT_ONE     = 2'd2;
    localparam logic [1:0] OUT_NONE    = 2'd3;

    localparam logic [1:0] SRC_A = 2'd0;
    localparam logic [1:0] SRC_B = 2'd1;
    localparam logic [1:0] SRC_C = 2'd2;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } qra_in_t;

    typedef struct packed {
        logic [ORD_W-1:0]         order_index;
        logic [1:0]               outcome;
        logic signed [COEF_W-1:0] root_plus;
        logic signed [COEF_W-1:0] root_minus;
        logic                     saturated;
        logic                     last_of_run;
    } qra_out_t;

    typedef struct packed {
        logic              start;
        logic [COEF_W-1:0] a;
        logic [COEF_W-1:0] b;
        logic [COEF_W-1:0] c;
    } qra_job_t;

    typedef struct packed {
        logic              done;
        logic [1:0]        outcome;
        logic [COEF_W-1:0] root_plus;
        logic [COEF_W-1:0] root_minus;
        logic              saturated;
    } qra_res_t;

    // source coefficient for position pos of ordering idx (abc acb bac bca cab cba)
    function automatic logic [1:0] order_src(logic [ORD_W-1:0] idx, logic [1:0] pos);
        logic [5:0] row;
        logic [1:0] src;
        case (idx)
            3'd0:    row = {SRC_A, SRC_B, SRC_C};
            3'd1:    row = {SRC_A, SRC_C, SRC_B};
            3'd2:    row = {SRC_B, SRC_A, SRC_C};
            3'd3:    row = {SRC_B, SRC_C, SRC_A};
            3'd4:    row = {SRC_C, SRC_A, SRC_B};
            3'd5:    row = {SRC_C, SRC_B, SRC_A};
            default: row = {SRC_A, SRC_B, SRC_C};
        endcase
        case (pos)
            2'd0:    src = row[5:4];
            2'd1:    src = row[3:2];
            2'd2:    src = row[1:0];
            default: src = SRC_A;
        endcase
        return src;
    endfunction

endpackage

[design/qra_order_sel.sv]
// marks the orderings whose value triple differs from every earlier ordering
module qra_order_sel
(
    input  qra_pkg::qra_in_t          coefs,
    output logic [qra_pkg::NUM_ORDERS-1:0] keep
);
    import qra_pkg::*;

    logic [COEF_W-1:0] v [3];
    logic [1:0]        pi;
    logic [1:0]        pj;
    logic              same;
    logic              dup;

    assign v[0] = coefs.coef_a;
    assign v[1] = coefs.coef_b;
    assign v[2] = coefs.coef_c;

    always_comb
    begin
        keep = '0;
        for (int i = 0; i < NUM_ORDERS; i++)
        begin
            dup = 1'b0;
            for (int j = 0; j < i; j++)
            begin
                same = 1'b1;
                for (int k = 0; k < 3; k++)
                begin
                    pi = order_src(ORD_W'(i), 2'(k));
                    pj = order_src(ORD_W'(j), 2'(k));
                    if (v[pi] != v[pj])
                        same = 1'b0;
                end
                if (same)
                    dup = 1'b1;
            end
            keep[i] = !dup;
        end
    end

endmodule

[design/qra_engine.sv]
// iterative solver for one ordering: shift-add multiply, digit sqrt, restoring divide
module qra_engine
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  qra_pkg::qra_job_t         job,
    input  logic [qra_pkg::TOL_W-1:0] tol,
    output qra_pkg::qra_res_t         res
);
    import qra_pkg::*;

    localparam int W  = COEF_W;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int DW = 2 * W + 2;
    localparam int SW = W + 1;
    localparam int RW = W + 4;
    localparam int NW = W + 2;
    localparam int QW = NW + F;
    localparam int VW = W + 2;
    localparam int CW = $clog2(QW + 1);
    localparam int MW = (W > TOL_W) ? W : TOL_W;
    localparam int TW = (DW > TOL_W + F) ? DW : TOL_W + F;

    localparam logic [3:0] E_IDLE   = 4'd0;
    localparam logic [3:0] E_MUL_B  = 4'd1;
    localparam logic [3:0] E_MUL_AC = 4'd2;
    localparam logic [3:0] E_DISC   = 4'd3;
    localparam logic [3:0] E_SQRT   = 4'd4;
    localparam logic [3:0] E_PREP   = 4'd5;
    localparam logic [3:0] E_DIV    = 4'd6;
    localparam logic [3:0] E_FIN    = 4'd7;
    localparam logic [3:0] E_DONE   = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  amag_reg, amag_next, bmag_reg, bmag_next, cmag_reg, cmag_next;
    logic          aneg_reg, aneg_next, bneg_reg, bneg_next, cneg_reg, cneg_next;
    logic [PW-1:0] prod_reg, prod_next, bb_reg, bb_next;
    logic [DW-1:0] rad_reg, rad_next;
    logic [SW-1:0] root_reg, root_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [QW-1:0] dq_reg, dq_next;
    logic [VW-1:0] drem_reg, drem_next;
    logic          qneg_reg, qneg_next, second_reg, second_next;
    logic          n2neg_reg, n2neg_next;
    logic [NW-1:0] n2mag_reg, n2mag_next;
    logic [1:0]    outcome_reg, outcome_next;
    logic [W-1:0]  rplus_reg, rplus_next, rminus_reg, rminus_next;
    logic          sat_reg, sat_next;

    logic [W-1:0]  ja_mag, jb_mag, jc_mag;
    logic          a_small;
    logic [W-1:0]  mul_x;
    logic [W:0]    mul_sum;
    logic [DW-1:0] bbx, ac4, dsum, dmag;
    logic [DW:0]   ddiff;
    logic          opp, dneg, d_two, d_zero;
    logic [RW-1:0] rem_sh, trial;
    logic [NW-1:0] bx, sx, b_sum, b_ms, s_mb;
    logic          b_ge_s;
    logic          n1neg;
    logic [NW-1:0] n1mag;
    logic [VW-1:0] dsh, dvs;
    logic          dge;
    logic [QW-1:0] limit;
    logic          over;
    logic [W-1:0]  qval, rval;

    assign ja_mag  = job.a[W-1] ? (~job.a + 1'b1) : job.a;
    assign jb_mag  = job.b[W-1] ? (~job.b + 1'b1) : job.b;
    assign jc_mag  = job.c[W-1] ? (~job.c + 1'b1) : job.c;
    assign a_small = (MW'(ja_mag) < MW'(tol)) || (ja_mag == '0);

    assign mul_x   = (state_reg == E_MUL_B) ? bmag_reg : amag_reg;
    assign mul_sum = {1'b0, prod_reg[PW-1:W]} + (prod_reg[0] ? {1'b0, mul_x} : '0);

    assign bbx    = {2'b00, bb_reg};
    assign ac4    = {prod_reg, 2'b00};
    assign dsum   = bbx + ac4;
    assign ddiff  = {1'b0, bbx} - {1'b0, ac4};
    assign opp    = (aneg_reg != cneg_reg) && (cmag_reg != '0);
    assign dneg   = !opp && ddiff[DW];
    assign dmag   = opp ? dsum : ddiff[DW-1:0];
    assign d_two  = !dneg && (TW'(dmag) > (TW'(tol) << F));
    assign d_zero = !dneg && (dmag == '0);

    assign rem_sh = {rem_reg[RW-3:0], rad_reg[DW-1:DW-2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    assign bx     = NW'(bmag_reg);
    assign sx     = NW'(root_reg);
    assign b_sum  = bx + sx;
    assign b_ms   = bx - sx;
    assign s_mb   = sx - bx;
    assign b_ge_s = bx >= sx;

    assign dsh = {drem_reg[VW-2:0], dq_reg[QW-1]};
    assign dvs = {1'b0, amag_reg, 1'b0};
    assign dge = dsh >= dvs;

    assign limit = qneg_reg ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - 1'b1);
    assign over  = dq_reg > limit;
    assign qval  = over ? limit[W-1:0] : dq_reg[W-1:0];
    assign rval  = qneg_reg ? (~qval + 1'b1) : qval;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        amag_next    = amag_reg;
        bmag_next    = bmag_reg;
        cmag_next    = cmag_reg;
        aneg_next    = aneg_reg;
        bneg_next    = bneg_reg;
        cneg_next    = cneg_reg;
        prod_next    = prod_reg;
        bb_next      = bb_reg;
        rad_next     = rad_reg;
        root_next    = root_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        drem_next    = drem_reg;
        qneg_next    = qneg_reg;
        second_next  = second_reg;
        n2neg_next   = n2neg_reg;
        n2mag_next   = n2mag_reg;
        outcome_next = outcome_reg;
        rplus_next   = rplus_reg;
        rminus_next  = rminus_reg;
        sat_next     = sat_reg;
        n1neg        = 1'b0;
        n1mag        = '0;
        case (state_reg)
            E_IDLE:
            begin
                if (job.start)
                begin
                    amag_next    = ja_mag;
                    bmag_next    = jb_mag;
                    cmag_next    = jc_mag;
                    aneg_next    = job.a[W-1];
                    bneg_next    = job.b[W-1];
                    cneg_next    = job.c[W-1];
                    rplus_next   = '0;
                    rminus_next  = '0;
                    sat_next     = 1'b0;
                    second_next  = 1'b0;
                    prod_next    = PW'(jb_mag);
                    cnt_next     = CW'(W);
                    outcome_next = OUT_INVALID;
                    state_next   = a_small ? E_DONE : E_MUL_B;
                end
            end
            E_MUL_B, E_MUL_AC:
            begin
                prod_next = {mul_sum, prod_reg[W-1:1]};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    if (state_reg == E_MUL_B)
                    begin
                        bb_next    = {mul_sum, prod_reg[W-1:1]};
                        prod_next  = PW'(cmag_reg);
                        cnt_next   = CW'(W);
                        state_next = E_MUL_AC;
                    end
                    else
                    begin
                        state_next = E_DISC;
                    end
                end
            end
            E_DISC:
            begin
                if (d_two)
                begin
                    outcome_next = OUT_TWO;
                    rad_next     = dmag;
                    root_next    = '0;
                    rem_next     = '0;
                    cnt_next     = CW'(SW);
                    state_next   = E_SQRT;
                end
                else if (d_zero)
                begin
                    outcome_next = OUT_ONE;
                    dq_next      = QW'(bx) << F;
                    drem_next    = '0;
                    qneg_next    = !bneg_reg ^ aneg_reg;
                    cnt_next     = CW'(QW);
                    state_next   = E_DIV;
                end
                else
                begin
                    outcome_next = OUT_NONE;
                    state_next   = E_DONE;
                end
            end
            E_SQRT:
            begin
                rad_next = {rad_reg[DW-3:0], 2'b00};
                cnt_next = cnt_reg - 1'b1;
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[SW-2:0], 1'b0};
                end
                if (cnt_reg == CW'(1))
                    state_next = E_PREP;
            end
            E_PREP:
            begin
                if (bneg_reg)
                begin
                    n1neg      = 1'b0;
                    n1mag      = b_sum;
                    n2neg_next = !b_ge_s;
                    n2mag_next = b_ge_s ? b_ms : s_mb;
                end
                else
                begin
                    n1neg      = b_ge_s;
                    n1mag      = b_ge_s ? b_ms : s_mb;
                    n2neg_next = 1'b1;
                    n2mag_next = b_sum;
                end
                dq_next    = QW'(n1mag) << F;
                drem_next  = '0;
                qneg_next  = n1neg ^ aneg_reg;
                cnt_next   = CW'(QW);
                state_next = E_DIV;
            end
            E_DIV:
            begin
                drem_next = dge ? (dsh - dvs) : dsh;
                dq_next   = {dq_reg[QW-2:0], dge};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    state_next = E_FIN;
            end
            E_FIN:
            begin
                sat_next = sat_reg | over;
                if (second_reg)
                begin
                    rminus_next = rval;
                    state_next  = E_DONE;
                end
                else
                begin
                    rplus_next = rval;
                    if (outcome_reg == OUT_TWO)
                    begin
                        second_next = 1'b1;
                        dq_next     = QW'(n2mag_reg) << F;
                        drem_next   = '0;
                        qneg_next   = n2neg_reg ^ aneg_reg;
                        cnt_next    = CW'(QW);
                        state_next  = E_DIV;
                    end
                    else
                    begin
                        state_next = E_DONE;
                    end
                end
            end
            E_DONE:
            begin
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= E_IDLE;
            cnt_reg    <= '0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amag_reg    <= amag_next;
        bmag_reg    <= bmag_next;
        cmag_reg    <= cmag_next;
        aneg_reg    <= aneg_next;
        bneg_reg    <= bneg_next;
        cneg_reg    <= cneg_next;
        prod_reg    <= prod_next;
        bb_reg      <= bb_next;
        rad_reg     <= rad_next;
        root_reg    <= root_next;
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        drem_reg    <= drem_next;
        qneg_reg    <= qneg_next;
        n2neg_reg   <= n2neg_next;
        n2mag_reg   <= n2mag_next;
        outcome_reg <= outcome_next;
        rplus_reg   <= rplus_next;
        rminus_reg  <= rminus_next;
        sat_reg     <= sat_next;
    end

    assign res.done       = (state_reg == E_DONE);
    assign res.outcome    = outcome_reg;
    assign res.root_plus  = rplus_reg;
    assign res.root_minus = rminus_reg;
    assign res.saturated  = sat_reg;

endmodule

[design/quadratic_roots_all_orderings_core.sv]
// top level: input capture, ordering walk, solver control and result register
//
// usage:
//   in channel (in_valid/in_ready/in_data) takes three signed Q16.16
//   coefficients; in_ready is high only while the block is idle.
//   out channel (out_valid/out_ready/out_data) gives one result per distinct
//   ordering of the three values, in ordering order, last_of_run set on the
//   final one of each input.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the tolerance; write it
//   only while idle.
// steps: an ordering with two real roots runs two W-step multiplies, a W+1 step
//   square root and two W+2+F step divides from its start to its transfer into
//   the output register; one root needs a single divide and no square root,
//   none needs neither, and a leading term too small skips all of them.
// a held result stops the walk: the next ordering starts only once the
//   result has moved into the output register.
// reset: tolerance returns to 66, all channels idle, no result pending.
module quadratic_roots_all_orderings_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  qra_pkg::qra_in_t          in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output qra_pkg::qra_out_t         out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [qra_pkg::TOL_W-1:0] cfg_data
);
    import qra_pkg::*;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_RUN  = 2'd1;
    localparam logic [1:0] T_WAIT = 2'd2;
    localparam logic [1:0] T_PUSH = 2'd3;

    logic [1:0]            state_reg, state_next;
    qra_in_t               coef_reg;
    logic [NUM_ORDERS-1:0] keep_reg, keep_in;
    logic [ORD_W-1:0]      idx_reg, idx_next;
    logic [TOL_W-1:0]      tol_reg;
    logic                  out_valid_reg, out_valid_next;
    qra_out_t              out_reg, out_next;
    qra_job_t              job;
    qra_res_t              res;
    logic [COEF_W-1:0]     v [3];
    logic [ORD_W-1:0]      nxt;
    logic                  more;
    logic                  in_xfer;
    logic                  push;

    qra_order_sel u_order_sel
    (
        .coefs (in_data),
        .keep  (keep_in)
    );

    qra_engine u_engine
    (
        .clk   (clk),
        .rst_n (rst_n),
        .job   (job),
        .tol   (tol_reg),
        .res   (res)
    );

    assign v[0] = coef_reg.coef_a;
    assign v[1] = coef_reg.coef_b;
    assign v[2] = coef_reg.coef_c;

    assign job.start = (state_reg == T_RUN);
    assign job.a     = v[order_src(idx_reg, 2'd0)];
    assign job.b     = v[order_src(idx_reg, 2'd1)];
    assign job.c     = v[order_src(idx_reg, 2'd2)];

    always_comb
    begin
        more = 1'b0;
        nxt  = idx_reg;
        for (int k = NUM_ORDERS - 1; k >= 0; k--)
        begin
            if (keep_reg[k] && (ORD_W'(k) > idx_reg))
            begin
                more = 1'b1;
                nxt  = ORD_W'(k);
            end
        end
    end

    assign in_ready  = (state_reg == T_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign push      = (state_reg == T_PUSH) && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            T_IDLE:
            begin
                if (in_xfer)
                begin
                    idx_next   = '0;
                    state_next = T_RUN;
                end
            end
            T_RUN:
            begin
                state_next = T_WAIT;
            end
            T_WAIT:
            begin
                if (res.done)
                    state_next = T_PUSH;
            end
            T_PUSH:
            begin
                if (push)
                begin
                    out_valid_next       = 1'b1;
                    out_next.order_index = idx_reg;
                    out_next.outcome     = res.outcome;
                    out_next.root_plus   = res.root_plus;
                    out_next.root_minus  = res.root_minus;
                    out_next.saturated   = res.saturated;
                    out_next.last_of_run = !more;
                    idx_next             = nxt;
                    state_next           = more ? T_RUN : T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            tol_reg       <= TOL_W'(66);
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                tol_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            coef_reg <= in_data;
            keep_reg <= keep_in;
        end
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        res.done |-> state_reg == T_WAIT)
        else $error("solver finished outside wait");

    a_unused_roots_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.outcome == OUT_INVALID || out_data.outcome == OUT_NONE)
        |-> out_data.root_plus == '0 && out_data.root_minus == '0 && !out_data.saturated)
        else $error("roots present without real solution");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.order_index < ORD_W'(NUM_ORDERS))
        else $error("ordering index out of range");
`endif

endmodule
